// ===== rtl/video_gate_array_registers_core_defines.svh =====
// ----------------------------------------------------------------------------
// video gate array register block assertion macros
// checks compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef VIDEO_GATE_ARRAY_REGISTERS_CORE_DEFINES_SVH
`define VIDEO_GATE_ARRAY_REGISTERS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every rising edge outside reset
`define VGAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every rising edge, reset included
`define VGAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VGAR_ASSERT(lbl, prop, msg)
`define VGAR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/vgar_pkg.sv =====
// ----------------------------------------------------------------------------
// vgar_pkg
// item types, register addresses and mode bit positions of the gate array
// ----------------------------------------------------------------------------
package vgar_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int PAGE_BYTES      = 16384;
  localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 72;
  localparam int S_PAD_W   = 6;
  localparam int M_PAD_W   = 4;

  typedef enum logic [1:0] {
    KIND_GA_WRITE   = 2'd0,
    KIND_PAGE_WRITE = 2'd1,
    KIND_STATUS     = 2'd2,
    KIND_TICK       = 2'd3
  } kind_t;

  // gate array register addresses below the palette range
  localparam logic [4:0] REG_MODE1  = 5'd0;
  localparam logic [4:0] REG_MASK   = 5'd1;
  localparam logic [4:0] REG_BORDER = 5'd2;
  localparam logic [4:0] REG_MODE2  = 5'd3;
  localparam logic [4:0] REG_RESET  = 5'd4;

  // mode_bits positions
  localparam int MB_HIBW  = 0;
  localparam int MB_GRAPH = 1;
  localparam int MB_16COL = 4;
  localparam int MB_2COL  = 6;

  // page register address mode codes and stored address modes
  localparam logic [1:0] PC_ALPHA = 2'd0;
  localparam logic [1:0] PC_GLOW  = 2'd1;
  localparam logic [1:0] PC_GHIGH = 2'd3;
  localparam logic [1:0] AM_ALPHA = 2'd0;
  localparam logic [1:0] AM_GLOW  = 2'd1;
  localparam logic [1:0] AM_GHIGH = 2'd2;

  localparam logic [2:0] DRAW_TEXT    = 3'd0;
  localparam logic [2:0] DRAW_2COL    = 3'd1;
  localparam logic [2:0] DRAW_16COL   = 3'd2;
  localparam logic [2:0] DRAW_HIBW    = 3'd3;
  localparam logic [2:0] DRAW_4COL    = 3'd4;

  localparam logic [3:0] CHAR_W_16COL  = 4'd4;
  localparam logic [3:0] CHAR_W_NORMAL = 4'd8;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        display_area;
    logic        vsync_active;
    logic [3:0]  last_dot;
    logic [3:0]  palette_query;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  status_byte;
    logic [2:0]  draw_mode;
    logic [3:0]  char_width;
    logic [16:0] crt_page_base;
    logic [16:0] cpu_page_base;
    logic [1:0]  address_mode;
    logic [3:0]  border_value;
    logic [3:0]  mask_value;
    logic [6:0]  mode_flags;
    logic [3:0]  palette_color;
    logic        crtc_advance;
  } out_item_t;

endpackage

// ===== rtl/vgar_regs.sv =====
// ----------------------------------------------------------------------------
// vgar_regs
// register state of the gate array, updated by one item per step, with the
// result item formed from the updated values
// ----------------------------------------------------------------------------
`include "video_gate_array_registers_core_defines.svh"

module vgar_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  vgar_pkg::in_item_t  item,
  output vgar_pkg::out_item_t result
);
  import vgar_pkg::*;

  logic       data_phase, data_phase_next;
  logic [4:0] selected_register, selected_register_next;
  logic [3:0] palette [PALETTE_ENTRIES];
  logic [3:0] palette_mask_reg, palette_mask_reg_next;
  logic [3:0] border_reg, border_reg_next;
  logic [6:0] mode_bits, mode_bits_next;
  logic [2:0] crt_page, crt_page_next;
  logic [2:0] cpu_page, cpu_page_next;
  logic [1:0] addr_mode_reg, addr_mode_reg_next;
  logic       tick_toggle, tick_toggle_next;

  logic       pal_we;
  logic [4:0] status;
  logic       adv;
  logic [2:0] draw_mode;

  always_comb begin
    data_phase_next        = data_phase;
    selected_register_next = selected_register;
    palette_mask_reg_next  = palette_mask_reg;
    border_reg_next        = border_reg;
    mode_bits_next         = mode_bits;
    crt_page_next          = crt_page;
    cpu_page_next          = cpu_page;
    addr_mode_reg_next     = addr_mode_reg;
    tick_toggle_next       = tick_toggle;
    pal_we                 = 1'b0;
    status                 = 5'd0;
    adv                    = 1'b0;
    case (item.kind)
      KIND_GA_WRITE: begin
        data_phase_next = ~data_phase;
        if (!data_phase) begin
          selected_register_next = item.data_byte[4:0];
        end else if (selected_register[4]) begin
          pal_we = 1'b1;
        end else begin
          case (selected_register)
            REG_MODE1:  mode_bits_next = {mode_bits[6:5], item.data_byte[4:0]};
            REG_MASK:   palette_mask_reg_next = item.data_byte[3:0];
            REG_BORDER: border_reg_next = item.data_byte[3:0];
            REG_MODE2:  mode_bits_next = {item.data_byte[3], item.data_byte[1],
                                          mode_bits[4:0]};
            REG_RESET:  ;
            default:    ;
          endcase
        end
      end
      KIND_PAGE_WRITE: begin
        crt_page_next = item.data_byte[2:0];
        // hi-bandwidth graphics uses page pairs, so the crt page is even
        if (mode_bits[MB_HIBW] && mode_bits[MB_GRAPH]) begin
          crt_page_next[0] = 1'b0;
        end
        cpu_page_next = item.data_byte[5:3];
        case (item.data_byte[7:6])
          PC_ALPHA: addr_mode_reg_next = AM_ALPHA;
          PC_GLOW:  addr_mode_reg_next = AM_GLOW;
          PC_GHIGH: addr_mode_reg_next = AM_GHIGH;
          default:  ;
        endcase
      end
      KIND_STATUS: begin
        data_phase_next = 1'b0;
        status = {item.last_dot[selected_register[1:0]], item.vsync_active,
                  1'b1, 1'b0, item.display_area};
      end
      KIND_TICK: begin
        if (mode_bits[MB_HIBW]) begin
          adv = 1'b1;
        end else begin
          tick_toggle_next = ~tick_toggle;
          adv = tick_toggle;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (!mode_bits_next[MB_GRAPH]) begin
      draw_mode = DRAW_TEXT;
    end else if (mode_bits_next[MB_2COL]) begin
      draw_mode = DRAW_2COL;
    end else if (mode_bits_next[MB_16COL]) begin
      draw_mode = DRAW_16COL;
    end else if (mode_bits_next[MB_HIBW]) begin
      draw_mode = DRAW_HIBW;
    end else begin
      draw_mode = DRAW_4COL;
    end
  end

  always_comb begin
    result.status_byte   = status;
    result.draw_mode     = draw_mode;
    result.char_width    = mode_bits_next[MB_16COL] ? CHAR_W_16COL : CHAR_W_NORMAL;
    result.crt_page_base = {crt_page_next, {PAGE_SHIFT{1'b0}}};
    result.cpu_page_base = {cpu_page_next, {PAGE_SHIFT{1'b0}}};
    result.address_mode  = addr_mode_reg_next;
    result.border_value  = border_reg_next;
    result.mask_value    = palette_mask_reg_next;
    result.mode_flags    = mode_bits_next;
    // forward a palette write that lands on the queried entry
    result.palette_color = (pal_we && (selected_register[3:0] == item.palette_query))
                           ? item.data_byte[3:0] : palette[item.palette_query];
    result.crtc_advance  = adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_phase        <= 1'b0;
      selected_register <= 5'd0;
      palette_mask_reg  <= 4'd0;
      border_reg        <= 4'd0;
      mode_bits         <= 7'd0;
      crt_page          <= 3'd0;
      cpu_page          <= 3'd0;
      addr_mode_reg     <= AM_ALPHA;
      tick_toggle       <= 1'b0;
    end else if (step) begin
      data_phase        <= data_phase_next;
      selected_register <= selected_register_next;
      palette_mask_reg  <= palette_mask_reg_next;
      border_reg        <= border_reg_next;
      mode_bits         <= mode_bits_next;
      crt_page          <= crt_page_next;
      cpu_page          <= cpu_page_next;
      addr_mode_reg     <= addr_mode_reg_next;
      tick_toggle       <= tick_toggle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        palette[i] <= 4'd0;
      end
    end else if (step && pal_we) begin
      palette[selected_register[3:0]] <= item.data_byte[3:0];
    end
  end

  `VGAR_ASSERT(a_status_clears_phase,
    step && (item.kind == KIND_STATUS) |=> !data_phase,
    "status read left the flip-flop in the data phase")
  `VGAR_ASSERT(a_hibw_page_even,
    step && (item.kind == KIND_PAGE_WRITE) && mode_bits[MB_HIBW] && mode_bits[MB_GRAPH]
      |=> !crt_page[0],
    "odd crt page in hi-bandwidth graphics")
  `VGAR_ASSERT(a_hibw_tick_advances,
    (item.kind == KIND_TICK) && mode_bits[MB_HIBW] |-> result.crtc_advance,
    "tick in hi-bandwidth mode did not advance the crtc")
  `VGAR_ASSERT_ALWAYS(a_advance_on_tick_only,
    result.crtc_advance |-> (item.kind == KIND_TICK),
    "crtc advance outside a tick")

endmodule

// ===== rtl/video_gate_array_registers_core.sv =====
// ----------------------------------------------------------------------------
// video_gate_array_registers_core
// gate array register block with stream input and result channels
// ----------------------------------------------------------------------------
// s_* carries one item per access: a gate array write, a page register write,
// a status read or a crtc tick, selected by s_tuser. every item gives exactly
// one result item on m_*, holding the status byte, the crtc advance and the
// current register view (draw mode, page bases, palette color and so on).
// an accepted item is held in the input register until it can move on, is
// decoded and applied to the register state, and its result is loaded into
// the output register, which drives m_tvalid and m_tdata.
// throughput is one item per cycle while m_tready stays high; the state
// update is a single decode between the input and output registers.
// when the receiver stalls the result holds in the output register, the
// input register keeps one more item, and s_tready drops after that.
// rst clears both channels and all register state, palette included, to
// zero: text mode, alpha addressing, address phase.
// ----------------------------------------------------------------------------
module video_gate_array_registers_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // data_byte[7:0], display_area, vsync_active, last_dot[3:0], palette_query[3:0]
  input  logic [vgar_pkg::S_TDATA_W-1:0]       s_tdata,
  // kind[1:0]
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // status_byte[4:0], draw_mode[2:0], char_width[3:0], crt_page_base[16:0],
  // cpu_page_base[16:0], address_mode[1:0], border_value[3:0], mask_value[3:0],
  // mode_flags[6:0], palette_color[3:0], crtc_advance
  output logic [vgar_pkg::M_TDATA_W-1:0]       m_tdata
);
  import vgar_pkg::*;

  logic      in_valid;
  in_item_t  in_item;
  logic      out_valid;
  logic [M_TDATA_W-1:0] out_data;
  logic      advance;
  out_item_t result;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind          <= kind_t'(s_tuser);
      in_item.data_byte     <= s_tdata[7:0];
      in_item.display_area  <= s_tdata[8];
      in_item.vsync_active  <= s_tdata[9];
      in_item.last_dot      <= s_tdata[13:10];
      in_item.palette_query <= s_tdata[17:14];
    end
  end

  vgar_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {{M_PAD_W{1'b0}}, result.crtc_advance, result.palette_color,
                   result.mode_flags, result.mask_value, result.border_value,
                   result.address_mode, result.cpu_page_base, result.crt_page_base,
                   result.char_width, result.draw_mode, result.status_byte};
    end
  end

endmodule
